>>> rtl/q4dq_pkg.sv
package q4dq_pkg;

    localparam int BLOCK_WEIGHTS = 32;
    localparam int PAIRS         = BLOCK_WEIGHTS / 2;
    localparam int POS_W         = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int NIB_W         = 4;
    localparam int NIB_BIAS      = 8;
    localparam int ACT_W         = 16;
    localparam int SCALE_W       = 16;
    // sum of two weight*activation products: 5-bit weights times 16-bit activations
    localparam int PAIR_W        = ACT_W + 5;
    localparam int PART_W        = PAIR_W + $clog2(PAIRS);
    localparam int PROD_W        = PART_W + SCALE_W + 1;
    localparam int TOTAL_W       = 56;

    typedef struct packed {
        logic accept;     // take the input word into the block partial
        logic last;       // accepted word ends the vector
        logic mul;        // scale the finished block partial
        logic acc;        // add the scaled partial into the total
        logic emit;       // load the output register and clear the vector
    } t_cmd;

    typedef struct packed {
        logic block_end;  // current pair closes a block
    } t_status;

endpackage

>>> rtl/q4dq_ctrl.sv
module q4dq_ctrl
    import q4dq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last_item,
    input  logic    i_ready,
    input  t_status i_status,
    output logic    o_ready,
    output logic    o_valid,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_RUN,
        S_MUL,
        S_ACC,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_last;
    logic   r_out_valid;
    t_cmd   n_cmd;

    always_comb begin
        n_cmd        = '0;
        n_cmd.accept = (r_state == S_RUN) && i_valid;
        n_cmd.last   = i_last_item;
        n_cmd.mul    = (r_state == S_MUL);
        n_cmd.acc    = (r_state == S_ACC);
        n_cmd.emit   = (r_state == S_EMIT) && (!r_out_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new word, or drop the old one once the receiver takes it
            if (n_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_RUN: begin
                    if (n_cmd.accept) begin
                        r_last <= i_last_item;
                        if (i_status.block_end) begin
                            r_state <= S_MUL;
                        end else if (i_last_item) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= r_last ? S_EMIT : S_RUN;
                end
                S_EMIT: begin
                    if (n_cmd.emit) begin
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_RUN);
    assign o_valid = r_out_valid;
    assign o_cmd   = n_cmd;

endmodule

>>> rtl/q4dq_datapath.sv
module q4dq_datapath
    import q4dq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [7:0]                i_packed_pair,
    input  logic [SCALE_W-1:0]        i_block_scale_in,
    input  logic signed [ACT_W-1:0]   i_act_even,
    input  logic signed [ACT_W-1:0]   i_act_odd,
    output t_status                   o_status,
    output logic signed [TOTAL_W-1:0] o_dot_sum
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAIRS - 1);

    logic [POS_W-1:0]          r_pos;
    logic [SCALE_W-1:0]        r_scale;
    logic signed [PART_W-1:0]  r_partial;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [TOTAL_W-1:0] r_total;
    logic signed [TOTAL_W-1:0] r_dot_sum;

    logic signed [4:0]         w_even;
    logic signed [4:0]         w_odd;
    logic signed [PAIR_W-1:0]  pair_sum;
    logic signed [PART_W-1:0]  n_partial;
    logic signed [TOTAL_W:0]   sum_wide;
    logic signed [TOTAL_W-1:0] n_total;

    always_comb begin
        w_even   = $signed({1'b0, i_packed_pair[NIB_W-1:0]}) - 5'sd8;
        w_odd    = $signed({1'b0, i_packed_pair[2*NIB_W-1:NIB_W]}) - 5'sd8;
        pair_sum = PAIR_W'(w_even) * PAIR_W'(i_act_even)
                 + PAIR_W'(w_odd) * PAIR_W'(i_act_odd);
        // first pair of a block restarts the partial
        if (r_pos == '0) begin
            n_partial = PART_W'(pair_sum);
        end else begin
            n_partial = r_partial + PART_W'(pair_sum);
        end
        sum_wide = (TOTAL_W + 1)'(r_total) + (TOTAL_W + 1)'(r_prod);
        // clamp when the carry disagrees with the sign
        if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1]) begin
            n_total = sum_wide[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                        : {1'b0, {(TOTAL_W-1){1'b1}}};
        end else begin
            n_total = sum_wide[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (r_pos == '0) begin
                    r_scale <= i_block_scale_in;
                end
                r_partial <= n_partial;
                if (r_pos == LAST_POS || i_cmd.last) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (i_cmd.mul) begin
                r_prod <= PROD_W'(r_partial) * PROD_W'($signed({1'b0, r_scale}));
            end
            if (i_cmd.acc) begin
                r_total <= n_total;
            end
            if (i_cmd.emit) begin
                r_dot_sum <= r_total;
                r_total   <= '0;
            end
        end
    end

    assign o_status.block_end = (r_pos == LAST_POS);
    assign o_dot_sum          = r_dot_sum;

endmodule

>>> rtl/q4_block_dequant_dot_product.sv
// Q4 block-dequantizing dot product.
// Input channel (i_valid / o_ready): one word per packed weight pair with its
// two Q4.12 activations; the block scale is sampled on the first pair of each
// block, and i_last_item marks the final pair of a vector.
// Output channel (o_valid / i_ready): one 56-bit Q.24 saturated dot product
// per vector, covering complete blocks only.
// Throughput: one word per cycle within a block. A word that closes a block
// holds off the input while the block partial is scaled in a registered
// multiply (S_MUL) and then added to the saturating total (S_ACC). A last
// word, after any such scaling, passes through S_EMIT, which waits for the
// output register to drain and then loads it, raising o_valid.
// The output register holds the result while the receiver stalls; the next
// vector streams in meanwhile, and only a following last word waits for the
// register to drain.
// Reset clears the pair position, the total and the output valid; the block
// is ready for a new vector once reset is released.
module q4_block_dequant_dot_product
    import q4dq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_packed_pair,
    input  logic [SCALE_W-1:0]        i_block_scale_in,
    input  logic signed [ACT_W-1:0]   i_act_even,
    input  logic signed [ACT_W-1:0]   i_act_odd,
    input  logic                      i_last_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [TOTAL_W-1:0] o_dot_sum
);

    t_cmd    cmd;
    t_status status;

    q4dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_item (i_last_item),
        .i_ready     (i_ready),
        .i_status    (status),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .o_cmd       (cmd)
    );

    q4dq_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_packed_pair    (i_packed_pair),
        .i_block_scale_in (i_block_scale_in),
        .i_act_even       (i_act_even),
        .i_act_odd        (i_act_odd),
        .o_status         (status),
        .o_dot_sum        (o_dot_sum)
    );

    a_block_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && status.block_end) |=> !o_ready)
        else $error("input taken while a finished block is being scaled");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last_item) |=> !o_ready)
        else $error("input taken before the vector result was loaded");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_valid)
        else $error("result load did not raise output valid");

endmodule
